[rtl/assert_macros.svh]
// Assertion macros used by the checker module of this project.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

[rtl/spq_pkg.sv]
// Shared types and defaults of the sorted priority queue.
// No dependencies.
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } spq_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

  // Result handshake from the engine to the output register.
  typedef struct packed {
    logic        valid;
    spq_status_t status;
  } spq_res_ctl_t;

endpackage

`default_nettype wire

[rtl/spq_req_if.sv]
// Request channel: valid/ready plus command and value.
// No dependencies.
`default_nettype none

interface spq_req_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [DATA_WIDTH-1:0] data_value;

  modport source (output valid, cmd, data_value, input ready);
  modport sink   (input valid, cmd, data_value, output ready);
endinterface

`default_nettype wire

[rtl/spq_rsp_if.sv]
// Response channel: valid/ready plus popped value, status and occupancy.
// No dependencies.
`default_nettype none

interface spq_rsp_if #(
  parameter int DATA_WIDTH = 32,
  parameter int DEPTH      = 16
);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] popped_value;
  logic [1:0]                   status;
  logic [CNT_W-1:0]             occupancy;

  modport source (output valid, popped_value, status, occupancy, input ready);
  modport sink   (input valid, popped_value, status, occupancy, output ready);
endinterface

`default_nettype wire

[rtl/spq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/spq_engine.sv]
// Queue engine: circular sorted store in RAM, insertion walk from the tail.
// Depends on spq_pkg; drives one spq_ram.
`default_nettype none

module spq_engine #(
  parameter int DEPTH      = spq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEFAULT,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W  = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request side
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire spq_pkg::spq_cmd_t     in_cmd,
  input  wire logic [DATA_WIDTH-1:0] in_value,
  // result side
  output spq_pkg::spq_res_ctl_t      res,
  output logic [DATA_WIDTH-1:0]      res_value,
  output logic [CNT_W-1:0]           res_occ,
  input  wire logic                  res_ready,
  // RAM side
  output logic                       ram_we,
  output logic [ADDR_W-1:0]          ram_waddr,
  output logic [DATA_WIDTH-1:0]      ram_wdata,
  output logic                       ram_re,
  output logic [ADDR_W-1:0]          ram_raddr,
  input  wire logic [DATA_WIDTH-1:0] ram_rdata
);

  import spq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_PUSH_CMP,
    S_PUSH_HEAD,
    S_RESULT
  } state_t;

  state_t              state;
  logic [ADDR_W-1:0]   head;
  logic [CNT_W-1:0]    count;
  logic [ADDR_W-1:0]   ptr;     // physical slot being compared
  logic [CNT_W-1:0]    remain;  // entries left to compare, including ptr
  logic [DATA_WIDTH-1:0] val;
  spq_status_t         res_status;

  logic [ADDR_W:0]     tail_sum;
  logic [ADDR_W-1:0]   tail;
  logic                stored_gt;

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a);
    return (a == ADDR_W'(DEPTH - 1)) ? '0 : a + ADDR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] a);
    return (a == '0) ? ADDR_W'(DEPTH - 1) : a - ADDR_W'(1);
  endfunction

  // last occupied slot: head + count - 1, wrapped
  assign tail_sum  = (ADDR_W + 1)'(head) + (ADDR_W + 1)'(count - CNT_W'(1));
  assign tail      = (tail_sum >= (ADDR_W + 1)'(DEPTH))
                   ? ADDR_W'(tail_sum - (ADDR_W + 1)'(DEPTH))
                   : tail_sum[ADDR_W-1:0];
  assign stored_gt = $signed(ram_rdata) > $signed(val);

  assign in_ready   = (state == S_IDLE);
  assign res.valid  = (state == S_RESULT);
  assign res.status = res_status;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head;
    ram_wdata = in_value;
    ram_re    = 1'b0;
    ram_raddr = head;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_POP) begin
            ram_re = (count != '0);
          end else if (count == '0) begin
            ram_we = 1'b1;
          end else if (count != CNT_W'(DEPTH)) begin
            ram_re    = 1'b1;
            ram_raddr = tail;
          end
        end
      end
      S_PUSH_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = wrap_inc(ptr);
        ram_wdata = stored_gt ? val : ram_rdata;
        if (!stored_gt && remain != CNT_W'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = wrap_dec(ptr);
        end
      end
      S_PUSH_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = val;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            val       <= in_value;
            res_value <= '0;
            if (in_cmd == CMD_POP) begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                res_occ    <= count;
                state      <= S_RESULT;
              end else begin
                res_status <= ST_OK;
                state      <= S_POP_RD;
              end
            end else if (count == CNT_W'(DEPTH)) begin
              res_status <= ST_FULL;
              res_occ    <= count;
              state      <= S_RESULT;
            end else if (count == '0) begin
              res_status <= ST_OK;
              count      <= CNT_W'(1);
              res_occ    <= CNT_W'(1);
              state      <= S_RESULT;
            end else begin
              res_status <= ST_OK;
              ptr        <= tail;
              remain     <= count;
              state      <= S_PUSH_CMP;
            end
          end
        end
        S_POP_RD: begin
          res_value <= ram_rdata;
          head      <= wrap_inc(head);
          count     <= count - CNT_W'(1);
          res_occ   <= count - CNT_W'(1);
          state     <= S_RESULT;
        end
        S_PUSH_CMP: begin
          if (stored_gt) begin
            count   <= count + CNT_W'(1);
            res_occ <= count + CNT_W'(1);
            state   <= S_RESULT;
          end else if (remain == CNT_W'(1)) begin
            state <= S_PUSH_HEAD;
          end else begin
            ptr    <= wrap_dec(ptr);
            remain <= remain - CNT_W'(1);
          end
        end
        S_PUSH_HEAD: begin
          count   <= count + CNT_W'(1);
          res_occ <= count + CNT_W'(1);
          state   <= S_RESULT;
        end
        S_RESULT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/sorted_priority_queue.sv]
// Sorted priority queue, top level. Holds up to DEPTH signed values in
// descending order in one RAM used as a circular buffer (head = largest).
// A pop reads the head slot and advances the head. A push walks from the
// tail toward the head, one stored entry per cycle, moving each entry that is
// not greater than the new value one slot back, and drops the value in the
// first gap behind a greater entry (or at the head). The one read port and
// one write port of the RAM set the walk rate. A new request is accepted
// only once the previous result has been handed off; the spacing is least
// for a full push, an empty pop or a push into an empty queue, and most for
// a push that lands at the head of a queue with DEPTH-1 entries.
// Depends on spq_pkg, spq_req_if, spq_rsp_if, spq_ram and spq_engine.
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH      = spq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEFAULT
) (
  input wire logic   clk,
  input wire logic   rst,
  spq_req_if.sink    req,
  spq_rsp_if.source  rsp
);

  import spq_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // engine <-> RAM
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // engine -> output register
  spq_res_ctl_t          res;
  logic [DATA_WIDTH-1:0] res_value;
  logic [CNT_W-1:0]      res_occ;
  logic                  res_ready;

  // output register: holds one finished result so the engine can take
  // the next transfer while the consumer stalls
  logic                  out_valid;
  logic [DATA_WIDTH-1:0] out_value;
  spq_status_t           out_status;
  logic [CNT_W-1:0]      out_occ;

  assign res_ready = !out_valid || rsp.ready;

  spq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  spq_engine #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_cmd    (spq_cmd_t'(req.cmd)),
    .in_value  (req.data_value),
    .res       (res),
    .res_value (res_value),
    .res_occ   (res_occ),
    .res_ready (res_ready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res.valid;
    end
    if (res_ready && res.valid) begin
      out_value  <= res_value;
      out_status <= res.status;
      out_occ    <= res_occ;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.popped_value = out_value;
  assign rsp.status       = out_status;
  assign rsp.occupancy    = out_occ;

endmodule

`default_nettype wire

[rtl/spq_checker.sv]
// Port-level checks of the sorted priority queue, bound to its top level.
// Depends on spq_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module spq_checker #(
  parameter int DEPTH      = spq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEFAULT,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  rsp_valid,
  input wire logic                  rsp_ready,
  input wire logic [DATA_WIDTH-1:0] popped_value,
  input wire logic [1:0]            status,
  input wire logic [CNT_W-1:0]      occupancy
);

  import spq_pkg::*;

  `ASSERT_IMP(a_occ_bound, clk, rst, rsp_valid, occupancy <= CNT_W'(DEPTH))
  `ASSERT_IMP(a_full_occ, clk, rst, rsp_valid && status == ST_FULL, occupancy == CNT_W'(DEPTH))
  `ASSERT_IMP(a_empty_res, clk, rst, rsp_valid && status == ST_EMPTY, occupancy == '0 && popped_value == '0)
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(popped_value) && $stable(occupancy))

endmodule

bind sorted_priority_queue spq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .popped_value (rsp.popped_value),
  .status       (rsp.status),
  .occupancy    (rsp.occupancy)
);

`default_nettype wire

[tb/tb_sorted_priority_queue.sv]
// Self-checking testbench for sorted_priority_queue: a shadow queue predicts every
// response; the responses are compared field by field as they come out.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and the sorted_priority_queue RTL.
`default_nettype none

module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int DEPTH      = DEPTH_DEFAULT;
  localparam int DATA_W     = DATA_WIDTH_DEFAULT;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  // Quiet period after the last response, derived from the longest accept
  // spacing of the RTL.
  localparam int DRAIN_WAIT = 2 * (DEPTH + 2);
  // Cycles with no transfer on either channel before the run is declared hung.
  localparam int HANG_LIMIT = 5000;
  localparam int MAX_PRINTS = 40;

  typedef logic signed [DATA_W-1:0] value_t;

  // One predicted response.
  typedef struct {
    value_t           popped;
    spq_status_t      status;
    logic [CNT_W-1:0] occupancy;
  } queue_response_t;

  logic clk;
  logic rst;

  spq_req_if #(.DATA_WIDTH(DATA_W))                 req ();
  spq_rsp_if #(.DATA_WIDTH(DATA_W), .DEPTH(DEPTH))  rsp ();

  sorted_priority_queue #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_W)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // ---------------------------------------------------------------------------
  // Shadow state and scoreboard
  // ---------------------------------------------------------------------------
  value_t          shadow_queue[$];       // descending, index 0 = head
  queue_response_t pending_responses[$];  // oldest first
  queue_response_t oldest;

  int send_idle_pct;
  int recv_idle_pct;

  int mismatches        = 0;
  int responses_checked = 0;
  int pushes_ok;
  int pushes_dropped;
  int pops_ok;
  int pops_empty;
  int quiet_cycles;

  // Apply one accepted operation to the shadow queue and queue up the
  // response it must produce.
  function automatic void apply_queue_op(spq_cmd_t op, value_t val);
    queue_response_t r;
    int              slot;
    r.popped = '0;
    r.status = ST_OK;
    if (op == CMD_PUSH) begin
      if (shadow_queue.size() >= DEPTH) begin
        r.status = ST_FULL;
        pushes_dropped++;
      end else begin
        // goes in front of the first entry not greater than it, so a new
        // value lands ahead of older equal values
        slot = shadow_queue.size();
        for (int i = 0; i < shadow_queue.size(); i++) begin
          if (val >= shadow_queue[i]) begin
            slot = i;
            break;
          end
        end
        shadow_queue.insert(slot, val);
        pushes_ok++;
      end
    end else begin
      if (shadow_queue.size() == 0) begin
        r.status = ST_EMPTY;
        pops_empty++;
      end else begin
        r.popped = shadow_queue.pop_front();
        pops_ok++;
      end
    end
    r.occupancy = CNT_W'(shadow_queue.size());
    pending_responses.push_back(r);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] MISMATCH response %0d %s: got %0d, expected %0d",
               $realtime, responses_checked, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Response side: ready changes at the falling edge, stalling at the
  // current receiver rate.
  // ---------------------------------------------------------------------------
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Response checker: a transfer is taken at the rising edge.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("with nothing outstanding, popped_value", rsp.popped_value, 0);
      end else begin
        oldest = pending_responses.pop_front();
        if (rsp.popped_value !== oldest.popped)
          report_mismatch("popped_value", rsp.popped_value, oldest.popped);
        if (rsp.status !== oldest.status)
          report_mismatch("status", rsp.status, oldest.status);
        if (rsp.occupancy !== oldest.occupancy)
          report_mismatch("occupancy", rsp.occupancy, oldest.occupancy);
      end
      responses_checked++;
    end
  end

  // Hang watchdog: any transfer on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d responses outstanding",
               HANG_LIMIT, pending_responses.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Drive one request at the falling edge, hold it until the transfer at a
  // rising edge, then predict. valid stays high into the next call, which
  // either replaces the payload or drops valid while it idles.
  task automatic send_request(spq_cmd_t op, value_t val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid      = 1'b1;
    req.cmd        = op;
    req.data_value = val;
    do @(posedge clk); while (!req.ready);
    apply_queue_op(op, val);
  endtask

  task automatic push_value(value_t val);
    send_request(CMD_PUSH, val);
  endtask

  task automatic pop_head();
    // payload is don't-care on a pop; random content exercises that
    send_request(CMD_POP, value_t'($urandom));
  endtask

  // Mostly wide random values, with extremes and a narrow band near zero so
  // that equal values are frequent.
  function automatic value_t random_value();
    case ($urandom_range(9)) inside
      0: begin
        case ($urandom_range(4))
          0:       return {1'b0, {(DATA_W-1){1'b1}}};
          1:       return {1'b1, {(DATA_W-1){1'b0}}};
          2:       return '0;
          3:       return '1;
          default: return value_t'(1);
        endcase
      end
      1, 2:    return value_t'($urandom_range(8)) - value_t'(4);
      default: return value_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Pops on the store straight out of reset.
  task automatic test_pop_when_empty();
    pop_head();
    pop_head();
  endtask

  // Signed extremes, zero, +-1 and an equal pair; the first pops must
  // return the largest positive value, then the newer of the two equal ones.
  task automatic test_signed_extremes();
    push_value({1'b0, {(DATA_W-1){1'b1}}});
    push_value({1'b1, {(DATA_W-1){1'b0}}});
    push_value('0);
    push_value('1);
    push_value(value_t'(1));
    push_value(value_t'(1));
    pop_head();
    pop_head();
  endtask

  // Fill to capacity with a mix of orders and duplicates, push once more
  // while full (dropped), then pop one to show the store was untouched.
  task automatic test_full_store();
    value_t fill_vals[12];
    fill_vals = '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  32'sh0000_0002, 32'shFFFF_FFFE, 32'sh0000_0000, 32'sh1234_5678,
                  32'shEDCB_A988, 32'sh0000_0001, 32'sh7FFF_FFFE, 32'sh8000_0001};
    foreach (fill_vals[i])
      push_value(fill_vals[i]);
    push_value(value_t'($urandom));
    pop_head();
  endtask

  // Random traffic in bursts: fill runs and drain runs reach full and empty
  // often, mixed runs interleave pushes and pops around the middle.
  task automatic test_random_traffic(int n_items);
    int sent;
    int burst_len;
    int burst_kind;
    sent = 0;
    while (sent < n_items) begin
      burst_kind = $urandom_range(9);
      burst_len  = $urandom_range(DEPTH + 3, 1);
      for (int i = 0; i < burst_len && sent < n_items; i++) begin
        if (burst_kind <= 3)
          push_value(random_value());
        else if (burst_kind <= 6)
          pop_head();
        else if ($urandom_range(1))
          push_value(random_value());
        else
          pop_head();
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    pushes_ok         = 0;
    pushes_dropped    = 0;
    pops_ok           = 0;
    pops_empty        = 0;
    send_idle_pct     = 28;
    recv_idle_pct     = 62;

    req.valid      = 1'b0;
    req.cmd        = CMD_PUSH;
    req.data_value = '0;

    // synchronous reset, released at a falling edge
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_pop_when_empty();
    test_signed_extremes();
    test_full_store();

    // sender idles lightly, receiver stalls heavily
    test_random_traffic(700);
    // roles swapped
    send_idle_pct = 62;
    recv_idle_pct = 28;
    test_random_traffic(700);
    // back to back, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(600);

    @(negedge clk);
    req.valid = 1'b0;

    // outstanding responses are bounded by the watchdog
    while (pending_responses.size() != 0)
      @(posedge clk);
    // quiet period: anything arriving now is an extra response
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d pushes stored, %0d pushes dropped on full, %0d pops, %0d on empty",
             pushes_ok, pushes_dropped, pops_ok, pops_empty);
    $display("%0d responses checked, %0d mismatches", responses_checked, mismatches);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_req_if.sv
rtl/spq_rsp_if.sv
rtl/spq_ram.sv
rtl/spq_engine.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
tb/tb_sorted_priority_queue.sv
